// File: rtl/bbs_pkg.sv
// shared types, widths and codes of the bilinear background scaler
`default_nettype none
package bbs_pkg;

    localparam int MAP_SIDE_DEF  = 64;
    localparam int MAP_WORDS_DEF = 4096;

    localparam int DIM_W    = 14;
    localparam int SRC_W    = 7;
    localparam int SRC_MAX  = 127;
    localparam int IDX_W    = 12;
    localparam int COLOR_W  = 24;
    localparam int POS_W    = 13;
    localparam int PROD_W   = 20;
    localparam int ADDR_W   = 14;
    localparam int DIV_W    = 26;
    localparam int SUM_W    = 21;
    localparam int NUM_W    = 34;
    localparam int CHAN_W   = 8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_SOURCE_WIDTH  = 2'd2,
        REG_SOURCE_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
    } req_t;

    typedef struct packed {
        logic [DIM_W-1:0]    w;
        logic [DIM_W-1:0]    h;
        logic [SRC_W-1:0]    sw;
        logic [SRC_W-1:0]    sh;
        logic [DIV_W-1:0]    div;
    } cfg_t;

endpackage
`default_nettype wire

// File: rtl/bbs_coord.sv
// coordinate clamp, scale and one-bit-per-stage division into the source grid
`default_nettype none
module bbs_coord #(
    parameter int QW = 6
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire bbs_pkg::req_t                in_req,
    input  wire logic [bbs_pkg::POS_W-1:0]    in_x,
    input  wire logic [bbs_pkg::POS_W-1:0]    in_y,
    input  wire bbs_pkg::cfg_t                cfg,
    output logic                              out_valid,
    output bbs_pkg::req_t                     out_req,
    output logic [QW-1:0]                     x1,
    output logic [bbs_pkg::POS_W-1:0]         x2,
    output logic [QW-1:0]                     y1,
    output logic [bbs_pkg::POS_W-1:0]         y2
);

    logic                          v_reg   [0:QW];
    bbs_pkg::req_t                 req_reg [0:QW];
    logic [bbs_pkg::PROD_W-1:0]    rx_reg  [0:QW];
    logic [bbs_pkg::PROD_W-1:0]    ry_reg  [0:QW];
    logic [QW-1:0]                 qx_reg  [0:QW];
    logic [QW-1:0]                 qy_reg  [0:QW];

    logic [bbs_pkg::DIM_W-1:0]     wm1, hm1;
    logic [bbs_pkg::POS_W-1:0]     xc, yc;
    logic [bbs_pkg::PROD_W-1:0]    bx_next, by_next;

    // saturate off-screen coordinates, then scale by the source size
    always_comb begin
        wm1 = cfg.w - bbs_pkg::DIM_W'(1);
        hm1 = cfg.h - bbs_pkg::DIM_W'(1);
        xc  = ({1'b0, in_x} > wm1) ? wm1[bbs_pkg::POS_W-1:0] : in_x;
        yc  = ({1'b0, in_y} > hm1) ? hm1[bbs_pkg::POS_W-1:0] : in_y;
        bx_next = bbs_pkg::PROD_W'(xc) * bbs_pkg::PROD_W'(cfg.sw);
        by_next = bbs_pkg::PROD_W'(yc) * bbs_pkg::PROD_W'(cfg.sh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            req_reg[0] <= in_req;
            rx_reg[0]  <= bx_next;
            ry_reg[0]  <= by_next;
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
        end
    end

    // quotient is below the source size, so QW restoring steps suffice
    for (genvar s = 1; s <= QW; s++) begin : g_div
        localparam int K = QW - s;
        logic [bbs_pkg::PROD_W:0]   dx, dy;
        logic [bbs_pkg::PROD_W-1:0] rx_next, ry_next;
        logic [QW-1:0]              qx_next, qy_next;

        always_comb begin
            dx = (bbs_pkg::PROD_W+1)'(cfg.w) << K;
            dy = (bbs_pkg::PROD_W+1)'(cfg.h) << K;
            rx_next = rx_reg[s-1];
            ry_next = ry_reg[s-1];
            qx_next = qx_reg[s-1];
            qy_next = qy_reg[s-1];
            if ({1'b0, rx_reg[s-1]} >= dx) begin
                rx_next    = rx_reg[s-1] - dx[bbs_pkg::PROD_W-1:0];
                qx_next[K] = 1'b1;
            end
            if ({1'b0, ry_reg[s-1]} >= dy) begin
                ry_next    = ry_reg[s-1] - dy[bbs_pkg::PROD_W-1:0];
                qy_next[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (adv) begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                req_reg[s] <= req_reg[s-1];
                rx_reg[s]  <= rx_next;
                ry_reg[s]  <= ry_next;
                qx_reg[s]  <= qx_next;
                qy_reg[s]  <= qy_next;
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_req   = req_reg[QW];
    assign x1        = qx_reg[QW];
    assign y1        = qy_reg[QW];
    assign x2        = rx_reg[QW][bbs_pkg::POS_W-1:0];
    assign y2        = ry_reg[QW][bbs_pkg::POS_W-1:0];

endmodule
`default_nettype wire

// File: rtl/bbs_fetch.sv
// neighbor addressing and the four source map copies
`default_nettype none
module bbs_fetch #(
    parameter int QW        = 6,
    parameter int MAP_WORDS = bbs_pkg::MAP_WORDS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             adv,
    input  wire logic                             in_valid,
    input  wire bbs_pkg::req_t                    in_req,
    input  wire logic [QW-1:0]                    x1,
    input  wire logic [bbs_pkg::POS_W-1:0]        x2,
    input  wire logic [QW-1:0]                    y1,
    input  wire logic [bbs_pkg::POS_W-1:0]        y2,
    input  wire bbs_pkg::cfg_t                    cfg,
    output logic                                  out_valid,
    output logic [3:0][bbs_pkg::COLOR_W-1:0]      corner,
    output logic [bbs_pkg::POS_W-1:0]             out_x2,
    output logic [bbs_pkg::POS_W-1:0]             out_y2,
    output logic [bbs_pkg::POS_W-1:0]             out_wx,
    output logic [bbs_pkg::POS_W-1:0]             out_hy
);

    localparam int AW  = $clog2(MAP_WORDS);
    localparam int AXW = (AW > bbs_pkg::ADDR_W) ? AW : bbs_pkg::ADDR_W;

    // first stage: base address, edge flags, complementary weights
    logic                          v1_reg;
    bbs_pkg::req_t                 req1_reg;
    logic [bbs_pkg::ADDR_W-1:0]    base_reg, base_next;
    logic                          right_reg, right_next, down_reg, down_next;
    logic [bbs_pkg::POS_W-1:0]     x2_1_reg, y2_1_reg, wx1_reg, hy1_reg;
    logic [bbs_pkg::POS_W-1:0]     wx_next, hy_next;
    logic [bbs_pkg::SRC_W-1:0]     sw1_reg;

    always_comb begin
        base_next  = bbs_pkg::ADDR_W'(y1) * bbs_pkg::ADDR_W'(cfg.sw) + bbs_pkg::ADDR_W'(x1);
        right_next = (8'(x1) + 8'd1) < 8'(cfg.sw);
        down_next  = (8'(y1) + 8'd1) < 8'(cfg.sh);
        wx_next    = bbs_pkg::POS_W'(cfg.w - bbs_pkg::DIM_W'(1) - bbs_pkg::DIM_W'(x2));
        hy_next    = bbs_pkg::POS_W'(cfg.h - bbs_pkg::DIM_W'(1) - bbs_pkg::DIM_W'(y2));
    end

    // second stage: four read addresses, or the write address
    logic                          v2_reg, we_reg, we_next;
    logic [bbs_pkg::COLOR_W-1:0]   color2_reg;
    logic [AXW-1:0]                addr_reg [4];
    logic [AXW-1:0]                addr_next [4];
    logic [3:0]                    ok2_reg, ok_next;
    logic [bbs_pkg::POS_W-1:0]     x2_2_reg, y2_2_reg, wx2_reg, hy2_reg;

    always_comb begin
        addr_next[0] = AXW'(base_reg);
        addr_next[1] = AXW'(base_reg) + AXW'(1);
        addr_next[2] = AXW'(base_reg) + AXW'(sw1_reg);
        addr_next[3] = AXW'(base_reg) + AXW'(sw1_reg) + AXW'(1);
        if (req1_reg.cmd == bbs_pkg::CMD_WRITE) begin
            addr_next[0] = AXW'(req1_reg.index);
        end
        for (int k = 0; k < 4; k++) begin
            ok_next[k] = {1'b0, addr_next[k]} < (AXW+1)'(MAP_WORDS);
        end
        // a neighbor past the right or bottom edge reads as black
        ok_next[1] = ok_next[1] & right_reg;
        ok_next[2] = ok_next[2] & down_reg;
        ok_next[3] = ok_next[3] & right_reg & down_reg;
        we_next    = v1_reg && (req1_reg.cmd == bbs_pkg::CMD_WRITE) && ok_next[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            we_reg <= 1'b0;
            out_valid <= 1'b0;
        end else if (adv) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg && (req1_reg.cmd == bbs_pkg::CMD_QUERY);
            we_reg    <= we_next;
            out_valid <= v2_reg;
        end
    end

    logic [3:0]                  ok3_reg;
    logic [bbs_pkg::COLOR_W-1:0] rd_reg [4];

    always_ff @(posedge aclk) begin
        if (adv) begin
            req1_reg   <= in_req;
            base_reg   <= base_next;
            right_reg  <= right_next;
            down_reg   <= down_next;
            sw1_reg    <= cfg.sw;
            x2_1_reg   <= x2;
            y2_1_reg   <= y2;
            wx1_reg    <= wx_next;
            hy1_reg    <= hy_next;

            color2_reg <= req1_reg.color;
            addr_reg   <= addr_next;
            ok2_reg    <= ok_next;
            x2_2_reg   <= x2_1_reg;
            y2_2_reg   <= y2_1_reg;
            wx2_reg    <= wx1_reg;
            hy2_reg    <= hy1_reg;

            ok3_reg    <= ok2_reg;
            out_x2     <= x2_2_reg;
            out_y2     <= y2_2_reg;
            out_wx     <= wx2_reg;
            out_hy     <= hy2_reg;
        end
    end

    // one copy per corner, every copy takes every write
    for (genvar k = 0; k < 4; k++) begin : g_map
        logic [bbs_pkg::COLOR_W-1:0] mem [MAP_WORDS];

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (we_reg) begin
                    mem[addr_reg[0][AW-1:0]] <= color2_reg;
                end
                rd_reg[k] <= mem[addr_reg[k][AW-1:0]];
            end
        end

        assign corner[k] = ok3_reg[k] ? rd_reg[k] : '0;
    end

endmodule
`default_nettype wire

// File: rtl/bbs_blend.sv
// per-channel weighting and pipelined division by (screen width - 1) * (screen height - 1)
`default_nettype none
module bbs_blend (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             adv,
    input  wire logic                             in_valid,
    input  wire logic [3:0][bbs_pkg::COLOR_W-1:0] corner,
    input  wire logic [bbs_pkg::POS_W-1:0]        x2,
    input  wire logic [bbs_pkg::POS_W-1:0]        y2,
    input  wire logic [bbs_pkg::POS_W-1:0]        wx,
    input  wire logic [bbs_pkg::POS_W-1:0]        hy,
    input  wire logic [bbs_pkg::DIV_W-1:0]        div,
    output logic                                  out_valid,
    output logic [bbs_pkg::COLOR_W-1:0]           color
);

    localparam int NST = bbs_pkg::CHAN_W;

    logic                         v1_reg;
    logic [bbs_pkg::SUM_W-1:0]    top_reg [3], bot_reg [3], top_next [3], bot_next [3];
    logic [bbs_pkg::POS_W-1:0]    y2_reg, hy_reg;
    logic [bbs_pkg::NUM_W-1:0]    num_next [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            top_next[c] = bbs_pkg::SUM_W'(corner[1][8*(2-c) +: 8]) * bbs_pkg::SUM_W'(x2)
                        + bbs_pkg::SUM_W'(corner[0][8*(2-c) +: 8]) * bbs_pkg::SUM_W'(wx);
            bot_next[c] = bbs_pkg::SUM_W'(corner[3][8*(2-c) +: 8]) * bbs_pkg::SUM_W'(x2)
                        + bbs_pkg::SUM_W'(corner[2][8*(2-c) +: 8]) * bbs_pkg::SUM_W'(wx);
            num_next[c] = bbs_pkg::NUM_W'(bot_reg[c]) * bbs_pkg::NUM_W'(y2_reg)
                        + bbs_pkg::NUM_W'(top_reg[c]) * bbs_pkg::NUM_W'(hy_reg);
        end
    end

    logic                         v_reg   [0:NST];
    logic [bbs_pkg::NUM_W-1:0]    rem_reg [0:NST][3];
    logic [bbs_pkg::CHAN_W-1:0]   q_reg   [0:NST][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            v1_reg   <= in_valid;
            v_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            top_reg    <= top_next;
            bot_reg    <= bot_next;
            y2_reg     <= y2;
            hy_reg     <= hy;
            rem_reg[0] <= num_next;
            for (int c = 0; c < 3; c++) begin
                q_reg[0][c] <= '0;
            end
        end
    end

    // the sum never exceeds 255 times the divisor, so eight steps give the channel
    for (genvar s = 1; s <= NST; s++) begin : g_div
        localparam int K = NST - s;
        logic [bbs_pkg::NUM_W-1:0]  dv;
        logic [bbs_pkg::NUM_W-1:0]  rem_next [3];
        logic [bbs_pkg::CHAN_W-1:0] q_next [3];

        always_comb begin
            dv = bbs_pkg::NUM_W'(div) << K;
            for (int c = 0; c < 3; c++) begin
                rem_next[c] = rem_reg[s-1][c];
                q_next[c]   = q_reg[s-1][c];
                if (rem_reg[s-1][c] >= dv) begin
                    rem_next[c]  = rem_reg[s-1][c] - dv;
                    q_next[c][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (adv) begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
            end
        end
    end

    assign out_valid = v_reg[NST];
    assign color     = {q_reg[NST][0], q_reg[NST][1], q_reg[NST][2]};

endmodule
`default_nettype wire

// File: rtl/bilinear_background_scaler.sv
// top level: configuration registers, pipeline and output skid buffer
`default_nettype none
// Bilinear background scaler. A write item (command 0) stores one 24-bit pixel
// of the source image; a query item (command 1) returns one interpolated
// screen pixel. The block takes one item per clock and returns one result per
// clock while the output is not stalled. With the default map the pipeline has
// 7 + 3 + 2 + 8 + 1 stages (a MAP_SIDE above 127 counts as 127), set by the
// one-bit-per-stage dividers for the grid position and for the final
// per-channel normalization. The source map is held as four copies, one per
// neighbor, each with one write and one read port; writes land in the same
// pipeline stage as reads, so writes and queries keep their order. Entries
// hold nothing defined until written. Configuration must be changed only with
// no item in flight; out-of-range screen sizes are saturated when written, and
// a source size keeps its low seven bits and is then saturated.
module bilinear_background_scaler #(
    parameter int MAP_SIDE  = bbs_pkg::MAP_SIDE_DEF,
    parameter int MAP_WORDS = bbs_pkg::MAP_WORDS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_command,
    input  wire logic [bbs_pkg::IDX_W-1:0]     s_map_index,
    input  wire logic [bbs_pkg::COLOR_W-1:0]   s_map_color,
    input  wire logic [bbs_pkg::POS_W-1:0]     s_pixel_x,
    input  wire logic [bbs_pkg::POS_W-1:0]     s_pixel_y,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bbs_pkg::COLOR_W-1:0]        m_color,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [bbs_pkg::DIM_W-1:0]     cfg_data
);

    localparam int SIDE_EFF = (MAP_SIDE < bbs_pkg::SRC_MAX) ? MAP_SIDE : bbs_pkg::SRC_MAX;
    localparam int QW       = $clog2(SIDE_EFF);
    localparam int SRC_RST  = (SIDE_EFF < 64) ? SIDE_EFF : 64;

    // configuration, saturated on write
    logic [bbs_pkg::DIM_W-1:0]    w_reg, h_reg, scr_next;
    logic [bbs_pkg::SRC_W-1:0]    sw_reg, sh_reg, src_next;
    logic [bbs_pkg::DIV_W-1:0]    div_reg;
    bbs_pkg::cfg_t                cfg;

    always_comb begin
        scr_next = cfg_data;
        if (cfg_data < bbs_pkg::DIM_W'(2)) begin
            scr_next = bbs_pkg::DIM_W'(2);
        end else if (cfg_data > bbs_pkg::DIM_W'(8192)) begin
            scr_next = bbs_pkg::DIM_W'(8192);
        end
        src_next = cfg_data[bbs_pkg::SRC_W-1:0];
        if (src_next == '0) begin
            src_next = bbs_pkg::SRC_W'(1);
        end else if (src_next > bbs_pkg::SRC_W'(SIDE_EFF)) begin
            src_next = bbs_pkg::SRC_W'(SIDE_EFF);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg  <= bbs_pkg::DIM_W'(1024);
            h_reg  <= bbs_pkg::DIM_W'(768);
            sw_reg <= bbs_pkg::SRC_W'(SRC_RST);
            sh_reg <= bbs_pkg::SRC_W'(SRC_RST);
        end else if (cfg_we) begin
            case (bbs_pkg::cfg_idx_t'(cfg_index))
                bbs_pkg::REG_SCREEN_WIDTH:  w_reg  <= scr_next;
                bbs_pkg::REG_SCREEN_HEIGHT: h_reg  <= scr_next;
                bbs_pkg::REG_SOURCE_WIDTH:  sw_reg <= src_next;
                bbs_pkg::REG_SOURCE_HEIGHT: sh_reg <= src_next;
                default: ;
            endcase
        end
    end

    // area divisor is only needed deep in the pipe
    always_ff @(posedge aclk) begin
        div_reg <= bbs_pkg::DIV_W'(w_reg - bbs_pkg::DIM_W'(1))
                 * bbs_pkg::DIV_W'(h_reg - bbs_pkg::DIM_W'(1));
    end

    assign cfg = '{w: w_reg, h: h_reg, sw: sw_reg, sh: sh_reg, div: div_reg};

    // pipeline
    logic          adv;
    bbs_pkg::req_t in_req;
    logic          c_valid;
    bbs_pkg::req_t c_req;
    logic [QW-1:0] c_x1, c_y1;
    logic [bbs_pkg::POS_W-1:0] c_x2, c_y2;
    logic          f_valid;
    logic [3:0][bbs_pkg::COLOR_W-1:0] f_corner;
    logic [bbs_pkg::POS_W-1:0] f_x2, f_y2, f_wx, f_hy;
    logic          p_valid;
    logic [bbs_pkg::COLOR_W-1:0] p_color;

    assign in_req  = '{cmd: s_command, index: s_map_index, color: s_map_color};
    assign s_ready = adv;

    bbs_coord #(.QW(QW)) u_coord (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_req    (in_req),
        .in_x      (s_pixel_x),
        .in_y      (s_pixel_y),
        .cfg       (cfg),
        .out_valid (c_valid),
        .out_req   (c_req),
        .x1        (c_x1),
        .x2        (c_x2),
        .y1        (c_y1),
        .y2        (c_y2)
    );

    bbs_fetch #(.QW(QW), .MAP_WORDS(MAP_WORDS)) u_fetch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (c_valid),
        .in_req    (c_req),
        .x1        (c_x1),
        .x2        (c_x2),
        .y1        (c_y1),
        .y2        (c_y2),
        .cfg       (cfg),
        .out_valid (f_valid),
        .corner    (f_corner),
        .out_x2    (f_x2),
        .out_y2    (f_y2),
        .out_wx    (f_wx),
        .out_hy    (f_hy)
    );

    bbs_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid),
        .corner    (f_corner),
        .x2        (f_x2),
        .y2        (f_y2),
        .wx        (f_wx),
        .hy        (f_hy),
        .div       (div_reg),
        .out_valid (p_valid),
        .color     (p_color)
    );

    // output register plus spare entry; the pipe moves while the spare is free
    logic                        main_v_reg, spare_v_reg;
    logic [bbs_pkg::COLOR_W-1:0] main_d_reg, spare_d_reg;
    logic                        push, pop;

    assign adv  = !spare_v_reg;
    assign push = p_valid && adv;
    assign pop  = main_v_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg  <= 1'b0;
            spare_v_reg <= 1'b0;
        end else if (pop) begin
            if (spare_v_reg) begin
                spare_v_reg <= 1'b0;
            end else begin
                main_v_reg <= push;
            end
        end else if (push) begin
            if (main_v_reg) begin
                spare_v_reg <= 1'b1;
            end else begin
                main_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            main_d_reg <= spare_v_reg ? spare_d_reg : p_color;
        end else if (push) begin
            if (main_v_reg) begin
                spare_d_reg <= p_color;
            end else begin
                main_d_reg <= p_color;
            end
        end
    end

    assign m_valid = main_v_reg;
    assign m_color = main_d_reg;

endmodule
`default_nettype wire
